// File: rtl/wsd_pkg.sv
// Package for the WebSocket frame deframer: shared types, constants and helpers.
// Used by the parser, queue, output stage and top level; depends on nothing.
package wsd_pkg;

    // Largest extended-length field taken for length code 127.
    localparam int WSD_MAX_LEN_BYTES = 8;

    // Depth of the queue between the parser and the output stage.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Header length codes: the code that selects the 16-bit extended length field, and the largest direct length.
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_MAX = 7'd125;

    // Frame type codes on the output.
    typedef enum logic [2:0] {
        FT_CONT   = 3'd0,
        FT_TEXT   = 3'd1,
        FT_BINARY = 3'd2,
        FT_CLOSE  = 3'd3,
        FT_PING   = 3'd4,
        FT_PONG   = 3'd5,
        FT_ERROR  = 3'd6
    } t_ftype;

    // Opcodes from the low nibble of the first header byte.
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Upper nibble value for FIN set with all reserved bits clear.
    localparam logic [3:0] FIN_ONLY = 4'h8;

    // One classified word travelling from the parser to the output stage.
    typedef struct packed {
        logic [7:0] data;      // raw payload byte, zero for an empty frame
        logic [7:0] key;       // mask key byte to apply
        logic       has_data;
        t_ftype     ftype;
        logic       fin;
        logic       last;
    } t_item;

    // Map an opcode to its frame type.
    function automatic t_ftype opcode_type(input logic [3:0] op);
        t_ftype ft;
        unique case (op)
            OP_CONT:   ft = FT_CONT;
            OP_TEXT:   ft = FT_TEXT;
            OP_BINARY: ft = FT_BINARY;
            OP_CLOSE:  ft = FT_CLOSE;
            OP_PING:   ft = FT_PING;
            OP_PONG:   ft = FT_PONG;
            default:   ft = FT_ERROR;
        endcase
        return ft;
    endfunction

endpackage

// File: rtl/wsd_front.sv
// Frame parser: walks the header, length and key bytes and classifies payload words.
// Depends on wsd_pkg for the item type and the opcode map.
module wsd_front #(
    parameter int MAX_LEN_BYTES = wsd_pkg::WSD_MAX_LEN_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output wsd_pkg::t_item o_item
);

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_hdr0, n_hdr0;
    logic        r_mask, n_mask;
    logic [63:0] r_remain, n_remain;
    logic [63:0] r_len, n_len;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_kpos, n_kpos;

    logic        push;
    logic        last;
    logic        has_data;
    logic [7:0]  key_byte;
    logic [63:0] len_cand;
    logic        mask_cand;
    logic        hdr_done;
    logic        remain_one;

    assign remain_one = (r_remain == 64'd1);

    // Key byte for the current payload index; the first key byte sits on top.
    always_comb begin
        unique case (r_kpos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // Next-state logic for one accepted byte.
    always_comb begin
        n_phase   = r_phase;
        n_hdr0    = r_hdr0;
        n_mask    = r_mask;
        n_remain  = r_remain;
        n_len     = r_len;
        n_key     = r_key;
        n_kpos    = r_kpos;
        push      = 1'b0;
        last      = 1'b0;
        has_data  = 1'b0;
        len_cand  = r_len;
        mask_cand = r_mask;
        hdr_done  = 1'b0;

        unique case (r_phase)
            PH_HDR1: begin
                n_mask    = i_byte[7];
                mask_cand = i_byte[7];
                n_key     = '0;
                if (i_byte[6:0] <= wsd_pkg::LEN_CODE_MAX) begin
                    len_cand = {57'd0, i_byte[6:0]};
                    n_len    = len_cand;
                    hdr_done = 1'b1;
                end else begin
                    n_len    = '0;
                    n_remain = (i_byte[6:0] == wsd_pkg::LEN_CODE_16) ? 64'd2
                                                                   : 64'(MAX_LEN_BYTES);
                    n_phase  = PH_EXTLEN;
                end
            end
            PH_EXTLEN: begin
                len_cand = {r_len[55:0], i_byte};
                n_len    = len_cand;
                n_remain = r_remain - 64'd1;
                hdr_done = remain_one;
            end
            PH_KEY: begin
                n_key    = {r_key[23:0], i_byte};
                n_remain = r_remain - 64'd1;
                if (remain_one) begin
                    // Key complete: the length is already held.
                    mask_cand = 1'b0;
                    hdr_done  = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_kpos   = r_kpos + 2'd1;
                n_remain = r_remain - 64'd1;
                push     = 1'b1;
                has_data = 1'b1;
                last     = remain_one;
                if (remain_one) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_hdr0  = i_byte;
                n_phase = PH_HDR1;
            end
        endcase

        // Header done: read key if masked, else start payload or push an empty word.
        if (hdr_done) begin
            if (mask_cand) begin
                n_remain = 64'd4;
                n_phase  = PH_KEY;
            end else begin
                n_kpos = '0;
                if (len_cand == 64'd0) begin
                    n_remain = '0;
                    n_phase  = PH_HDR0;
                    push     = 1'b1;
                    last     = 1'b1;
                end else begin
                    n_remain = len_cand;
                    n_phase  = PH_PAYLOAD;
                end
            end
        end
    end

    // State registers advance only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_hdr0   <= '0;
            r_mask   <= 1'b0;
            r_remain <= '0;
            r_len    <= '0;
            r_key    <= '0;
            r_kpos   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_hdr0   <= n_hdr0;
            r_mask   <= n_mask;
            r_remain <= n_remain;
            r_len    <= n_len;
            r_key    <= n_key;
            r_kpos   <= n_kpos;
        end
    end

    // Classified word for the queue.
    assign o_push          = i_accept & push;
    assign o_item.data     = has_data ? i_byte : 8'd0;
    assign o_item.key      = has_data ? key_byte : 8'd0;
    assign o_item.has_data = has_data;
    assign o_item.ftype    = wsd_pkg::opcode_type(r_hdr0[3:0]);
    assign o_item.fin      = (r_hdr0[7:4] == wsd_pkg::FIN_ONLY);
    assign o_item.last     = last;

endmodule

// File: rtl/wsd_queue.sv
// Short queue of classified words between the parser and the output stage.
// Depends on wsd_pkg for the item type and the queue depth.
module wsd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsd_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output wsd_pkg::t_item o_item
);

    wsd_pkg::t_item                 r_mem [wsd_pkg::QDEPTH];
    logic [wsd_pkg::QPTR_W-1:0]     r_wptr, r_rptr;
    logic [wsd_pkg::QCNT_W-1:0]     r_count, n_count;

    assign o_full  = (r_count == wsd_pkg::QCNT_W'(wsd_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// File: rtl/wsd_back.sv
// Output stage: unmasks the queued word and holds it on the result channel.
// Depends on wsd_pkg for the item type.
module wsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  wsd_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_data,
    output logic [4:0]     o_user,
    output logic           o_last
);

    logic       r_valid;
    logic [7:0] r_data;
    logic [4:0] r_user;
    logic       r_last;

    // Load a new word when the register is free or being taken.
    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: unmask and pack the flags.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_item.data ^ i_item.key;
            r_user <= {i_item.fin, i_item.ftype, i_item.has_data};
            r_last <= i_item.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

// File: rtl/websocket_frame_deframer.sv
// WebSocket frame deframer top level: parser, queue and output stage.
// Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+--------------------------------------
//  s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready | tdata[7:0] stream byte
//  m_axis   | out | o_m_axis_tvalid/i_m_axis_tready | tdata payload byte, tuser flags, tlast
//
// One stream byte is taken every cycle while the four-word queue has room.
// A result passes from its byte through the queue and then the output register.
// The parser tracks the frame length in a 64-bit counter.
// Reset is synchronous and active low; it returns the parser to the first header byte.
// A stalled output fills the queue, after which the input is held off.
module websocket_frame_deframer #(
    parameter int MAX_LEN_BYTES = wsd_pkg::WSD_MAX_LEN_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] stream_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] payload_byte
    output logic [4:0] o_m_axis_tuser,   // [0] has_data, [3:1] frame_type, [4] final_fragment
    output logic       o_m_axis_tlast    // last_of_frame
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    wsd_pkg::t_item front_item;
    wsd_pkg::t_item head_item;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    wsd_front #(
        .MAX_LEN_BYTES(MAX_LEN_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .o_push   (push),
        .o_item   (front_item)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (head_item)
    );

    wsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// File: rtl/wsd_checker.sv
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends only on the top level's ports.
module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [4:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("result word changed while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // An empty-frame word carries zero data and closes the frame.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |->
            (o_m_axis_tdata == 8'd0 && o_m_axis_tlast))
        else $error("empty-frame word malformed");

    // The frame type field never carries the unused code.
    a_ftype: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[3:1] != 3'd7))
        else $error("frame type out of range");

    // The input handshake is always known, and an offered word carries known data.
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_s_axis_tready, i_s_axis_tvalid})
        && (!i_s_axis_tvalid || !$isunknown(i_s_axis_tdata)))
        else $error("input handshake or data unknown");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
